// ----- hdl/mts_pkg.sv -----
// Package for the min-tracking stack: item structs, operation and status codes,
// and the shift control that the top level sends to the row of stack cells.
// Depends on nothing; every other file imports it.
package mts_pkg;

  // Operation carried by an input item.
  typedef enum logic [0:0] {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  // Status reported in every result item.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2
  } status_t;

  // Input item.
  typedef struct packed {
    func_t              func;
    logic signed [31:0] push_value;
  } in_item_t;

  // Result item.
  typedef struct packed {
    status_t            status;
    logic signed [31:0] current_min;
    logic signed [31:0] top_value;
    logic [8:0]         fill_count;
  } out_item_t;

  // Shift command for every cell of the stack row.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

endpackage

// ----- hdl/mts_cell.sv -----
// One stack cell: holds an entry value and the minimum that held before it was pushed.
// Depends on mts_pkg for the shift command struct.
module mts_cell #(
  parameter int W = 32
) (
  input  logic                clk,
  input  mts_pkg::shift_ctl_t ctl,
  input  logic [W-1:0]        up_value,
  input  logic [W-1:0]        up_prior,
  input  logic [W-1:0]        down_value,
  input  logic [W-1:0]        down_prior,
  output logic [W-1:0]        value,
  output logic [W-1:0]        prior
);
  import mts_pkg::*;

  // A push moves every entry one cell deeper; a pop moves every entry one cell up.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      value <= up_value;
      prior <= up_prior;
    end else if (ctl.pop) begin
      value <= down_value;
      prior <= down_prior;
    end
  end

endmodule

// ----- hdl/min_tracking_stack.sv -----
// Top level of the min-tracking stack: control, running minimum, result register
// and the row of mts_cell instances. Depends on mts_pkg and mts_cell.
//
//   channel   signals                      direction  payload
//   in        in_valid in_ready in_item    input      in_item_t  (func, push_value)
//   out       out_valid out_ready out_item output     out_item_t (status, min, top, fill)
//
// One item is taken per clock cycle; its result appears in the output register on
// the next cycle. Cell 0 of the row is the top of the stack, so a push or pop shifts
// the whole row when the item is taken. A stalled result holds the input side only
// until it is taken; the input is ready whenever the output register is empty or
// draining. Reset clears the fill count and output valid and sets the minimum to the
// largest value; cell contents are left as they are and never read before written.
module min_tracking_stack #(
  parameter int DEPTH      = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mts_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output mts_pkg::out_item_t out_item
);
  import mts_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS - 1){1'b1}}};
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [VALUE_BITS-1:0] running_min;
  logic [VALUE_BITS-1:0] running_min_next;
  logic [VALUE_BITS-1:0] top_next;
  logic [VALUE_BITS-1:0] new_value;
  status_t               status_next;
  shift_ctl_t            ctl;
  logic                  in_fire;
  logic                  is_push;
  logic                  full;
  logic                  empty;

  logic [VALUE_BITS-1:0] cell_value [DEPTH];
  logic [VALUE_BITS-1:0] cell_prior [DEPTH];

  logic [VALUE_BITS+31:0] value_ext;
  logic [VALUE_BITS+31:0] min_wide;
  logic [VALUE_BITS+31:0] top_wide;
  logic [CW+8:0]          count_wide;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_push  = (in_item.func == FUNC_PUSH);
  assign full     = (count == FULL_COUNT);
  assign empty    = (count == '0);

  // Input value is sign extended and then cut to the stack's value width.
  assign value_ext = {{VALUE_BITS{in_item.push_value[31]}}, in_item.push_value};
  assign new_value = value_ext[VALUE_BITS-1:0];

  // Shift command for the row of cells.
  always_comb begin
    ctl.push = in_fire && is_push && !full;
    ctl.pop  = in_fire && !is_push && !empty;
  end

  // Next count, minimum, top and status for the accepted item.
  always_comb begin
    count_next       = count;
    running_min_next = running_min;
    status_next      = ST_OK;
    top_next         = empty ? '0 : cell_value[0];
    if (is_push) begin
      if (full) begin
        status_next = ST_PUSH_FULL;
      end else begin
        count_next = count + 1'b1;
        top_next   = new_value;
        if ($signed(new_value) < $signed(running_min)) begin
          running_min_next = new_value;
        end
      end
    end else begin
      if (empty) begin
        status_next = ST_POP_EMPTY;
      end else begin
        count_next       = count - 1'b1;
        running_min_next = cell_prior[0];
        top_next         = (count == CW'(1)) ? '0 : cell_value[1];
      end
    end
  end

  // Result fields at their port widths.
  assign min_wide   = {32'd0, running_min_next};
  assign top_wide   = {32'd0, top_next};
  assign count_wide = {9'd0, count_next};

  // Control state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      running_min <= VMAX;
      out_valid   <= 1'b0;
    end else begin
      if (in_fire) begin
        count       <= count_next;
        running_min <= running_min_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_item.status      <= status_next;
      out_item.current_min <= min_wide[31:0];
      out_item.top_value   <= top_wide[31:0];
      out_item.fill_count  <= count_wide[8:0];
    end
  end

  // Row of cells; cell 0 is the top of the stack.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_BITS-1:0] up_value;
    logic [VALUE_BITS-1:0] up_prior;
    logic [VALUE_BITS-1:0] down_value;
    logic [VALUE_BITS-1:0] down_prior;

    if (i == 0) begin : g_top
      assign up_value = new_value;
      assign up_prior = running_min;
    end else begin : g_mid
      assign up_value = cell_value[i-1];
      assign up_prior = cell_prior[i-1];
    end

    if (i == DEPTH - 1) begin : g_bottom
      assign down_value = cell_value[i];
      assign down_prior = cell_prior[i];
    end else begin : g_inner
      assign down_value = cell_value[i+1];
      assign down_prior = cell_prior[i+1];
    end

    mts_cell #(
      .W (VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .up_value   (up_value),
      .up_prior   (up_prior),
      .down_value (down_value),
      .down_prior (down_prior),
      .value      (cell_value[i]),
      .prior      (cell_prior[i])
    );
  end

  // The fill count never passes the stack depth.
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("fill count above depth");

  // An empty stack always reports the largest value as its minimum.
  a_empty_min : assert property (@(posedge clk) disable iff (rst)
    empty |-> running_min == VMAX)
    else $error("minimum not restored on empty stack");

  // A pop taken on an empty stack reports that status and leaves the count alone.
  a_pop_empty : assert property (@(posedge clk) disable iff (rst)
    (in_fire && !is_push && empty) |=>
      (out_item.status == ST_POP_EMPTY && count == '0))
    else $error("pop on empty mishandled");

  // A push that fits grows the count by one.
  a_push_count : assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_push && !full) |=> count == CW'($past(count) + 1'b1))
    else $error("push did not grow the count");

endmodule
